### design/aae_pkg.sv
// ----------------------------------------------------------------------------
// aae_pkg
// Shared types and constants for the AD / ASD envelope pair.
// ----------------------------------------------------------------------------
package aae_pkg;

    localparam int LEVEL_W = 25;
    localparam int ACC_W   = 27;
    localparam int MV_W    = 15;
    localparam int PCNT_W  = 16;
    localparam int SETTLE_W = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 25;

    localparam int SETTLE_TICKS_DEFAULT = 2;

    localparam logic [LEVEL_W-1:0] LEVEL_ONE = 25'h100_0000;

    localparam logic signed [MV_W-1:0] GATE_HIGH_MV  = 15'sd1000;
    localparam logic signed [MV_W-1:0] GATE_LOW_MV   = 15'sd0;
    localparam logic signed [MV_W-1:0] CHAIN_HIGH_MV = 15'sd10000;

    localparam logic [CFG_DATA_W-1:0] STEP_RESET    = 25'd51700;
    localparam logic [CFG_DATA_W-1:0] SUSTAIN_RESET = 25'd1677722;
    localparam logic [PCNT_W-1:0]     PULSE_RESET   = 16'd48;

    typedef enum logic [1:0] {
        ST_OFF,
        ST_ATTACK,
        ST_SUSTAIN,
        ST_RELEASE
    } stage_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AD_ATTACK_STEP,
        CFG_AD_RELEASE_STEP,
        CFG_ASD_ATTACK_STEP,
        CFG_ASD_RELEASE_STEP,
        CFG_SUSTAIN_LEVEL,
        CFG_SUSTAIN_MODE,
        CFG_EOA_PULSE_TICKS
    } cfg_index_t;

    typedef struct packed {
        stage_t                    stage;
        logic signed [ACC_W-1:0]   acc;
        logic [LEVEL_W-1:0]        level;
        logic [PCNT_W-1:0]         pulse_count;
        logic                      release_done;
        logic                      gate_high;
    } env_state_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] attack_step;
        logic [LEVEL_W-1:0] release_step;
        logic [LEVEL_W-1:0] target;
        logic               hold_mode;
        logic               early_clear;
        logic [PCNT_W-1:0]  pulse_ticks;
    } env_ctrl_t;

    localparam env_state_t ENV_RESET = '{
        stage:        ST_OFF,
        acc:          '0,
        level:        '0,
        pulse_count:  '0,
        release_done: 1'b1,
        gate_high:    1'b0
    };

endpackage

### design/aae_env_step.sv
// ----------------------------------------------------------------------------
// aae_env_step
// One tick of a single linear envelope: Schmitt gate, retrigger, stage
// transition, ramp and end-of-attack pulse count.
// ----------------------------------------------------------------------------
module aae_env_step
(
    input  aae_pkg::env_state_t                  cur,
    input  aae_pkg::env_ctrl_t                   ctrl,
    input  logic signed [aae_pkg::MV_W-1:0]      mv,
    input  logic                                 settling,
    input  logic                                 use_ext_held,
    input  logic                                 ext_held,
    output aae_pkg::env_state_t                  nxt,
    output logic                                 eoa
);

    aae_pkg::env_state_t       mid;
    logic                      edge_seen;
    logic                      held;
    logic signed [aae_pkg::ACC_W-1:0] target_acc;

    assign target_acc = $signed({2'b00, ctrl.target});

    always_comb
    begin
        mid       = cur;
        edge_seen = 1'b0;
        if (cur.gate_high)
        begin
            if (mv <= aae_pkg::GATE_LOW_MV)
            begin
                mid.gate_high = 1'b0;
            end
        end
        else if (mv >= aae_pkg::GATE_HIGH_MV)
        begin
            mid.gate_high = 1'b1;
            edge_seen     = 1'b1;
        end
        held = use_ext_held ? ext_held : mid.gate_high;

        if (edge_seen && !settling)
        begin
            mid.stage        = aae_pkg::ST_ATTACK;
            mid.acc          = '0;
            mid.level        = '0;
            mid.pulse_count  = '0;
            mid.release_done = 1'b1;
        end

        case (mid.stage)
            aae_pkg::ST_ATTACK:
            begin
                if (ctrl.early_clear)
                begin
                    mid.release_done = 1'b0;
                end
                if (mid.acc >= target_acc)
                begin
                    if (mid.pulse_count < ctrl.pulse_ticks)
                    begin
                        mid.pulse_count = ctrl.pulse_ticks;
                    end
                    mid.release_done = 1'b0;
                    mid.acc          = target_acc;
                    mid.level        = ctrl.target;
                    mid.stage        = ctrl.hold_mode ? aae_pkg::ST_SUSTAIN
                                                      : aae_pkg::ST_RELEASE;
                end
            end
            aae_pkg::ST_SUSTAIN:
            begin
                if (!held)
                begin
                    mid.stage = aae_pkg::ST_RELEASE;
                end
            end
            aae_pkg::ST_RELEASE:
            begin
                if (mid.acc <= $signed({aae_pkg::ACC_W{1'b0}}))
                begin
                    mid.release_done = 1'b1;
                    mid.stage        = aae_pkg::ST_OFF;
                    mid.acc          = '0;
                    mid.level        = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        nxt = mid;
        case (mid.stage)
            aae_pkg::ST_ATTACK:
            begin
                nxt.acc = mid.acc + $signed({2'b00, ctrl.attack_step});
                if (nxt.acc > $signed({2'b00, aae_pkg::LEVEL_ONE}))
                begin
                    nxt.level = aae_pkg::LEVEL_ONE;
                end
                else
                begin
                    nxt.level = nxt.acc[aae_pkg::LEVEL_W-1:0];
                end
            end
            aae_pkg::ST_RELEASE:
            begin
                nxt.acc = mid.acc - $signed({2'b00, ctrl.release_step});
                if (nxt.acc < $signed({aae_pkg::ACC_W{1'b0}}))
                begin
                    nxt.level = '0;
                end
                else
                begin
                    nxt.level = nxt.acc[aae_pkg::LEVEL_W-1:0];
                end
            end
            aae_pkg::ST_OFF:
            begin
                nxt.level = '0;
            end
            default:
            begin
            end
        endcase
        if (mid.pulse_count != '0)
        begin
            nxt.pulse_count = mid.pulse_count - 1'b1;
            eoa             = 1'b1;
        end
        else
        begin
            eoa = 1'b0;
        end
    end

endmodule

### design/ad_and_asr_envelope_pair_top.sv
// ----------------------------------------------------------------------------
// ad_and_asr_envelope_pair_top
// AD and ASD envelope pair, one sample tick per item.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item passes the input register, then the result register
// around one envelope update.
// Throughput: 1 item per cycle while the output is not stalled by m_tready.
// Reset: config and state registers load their defaults, both envelopes are off
// with end-of-release set, and edges of the first SETTLE_TICKS items are ignored.
// ----------------------------------------------------------------------------
module ad_and_asr_envelope_pair_top
#(
    parameter int SETTLE_TICKS = aae_pkg::SETTLE_TICKS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    // s_tdata: ad_trigger_mv[14:0], asd_trigger_mv[29:15],
    //          asd_trigger_patched[30], zero[31]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // m_tdata: ad_level[24:0], ad_end_of_attack[25], ad_end_of_release[26],
    //          asd_level[51:27], asd_end_of_attack[52],
    //          asd_end_of_release[53], zero[55:54]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,
    input  logic        wr_en,
    input  logic [aae_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [aae_pkg::CFG_DATA_W-1:0] wr_data
);

    localparam int LW = aae_pkg::LEVEL_W;
    localparam int MW = aae_pkg::MV_W;

    logic [LW-1:0] ad_attack_step_reg;
    logic [LW-1:0] ad_release_step_reg;
    logic [LW-1:0] asd_attack_step_reg;
    logic [LW-1:0] asd_release_step_reg;
    logic [LW-1:0] sustain_level_reg;
    logic          sustain_mode_reg;
    logic [aae_pkg::PCNT_W-1:0] eoa_pulse_ticks_reg;

    logic          in_valid_reg;
    logic [2*MW:0] in_data_reg;
    logic          out_valid_reg;
    logic [55:0]   out_data_reg;
    logic [55:0]   out_data_next;

    aae_pkg::env_state_t ad_reg, ad_next;
    aae_pkg::env_state_t asd_reg, asd_next;
    logic [aae_pkg::SETTLE_W-1:0] settle_reg;

    aae_pkg::env_ctrl_t ad_ctrl, asd_ctrl;
    logic               advance;
    logic               settling;
    logic               chained;
    logic               ad_eoa, asd_eoa;
    logic [LW-1:0]      sus;
    logic [LW-1:0]      asd_out;
    logic signed [MW-1:0] ad_mv, asd_mv_in, asd_mv;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ad_attack_step_reg   <= aae_pkg::STEP_RESET;
            ad_release_step_reg  <= aae_pkg::STEP_RESET;
            asd_attack_step_reg  <= aae_pkg::STEP_RESET;
            asd_release_step_reg <= aae_pkg::STEP_RESET;
            sustain_level_reg    <= aae_pkg::SUSTAIN_RESET;
            sustain_mode_reg     <= 1'b0;
            eoa_pulse_ticks_reg  <= aae_pkg::PULSE_RESET;
        end
        else if (wr_en)
        begin
            case (wr_index)
                aae_pkg::CFG_AD_ATTACK_STEP:   ad_attack_step_reg   <= wr_data;
                aae_pkg::CFG_AD_RELEASE_STEP:  ad_release_step_reg  <= wr_data;
                aae_pkg::CFG_ASD_ATTACK_STEP:  asd_attack_step_reg  <= wr_data;
                aae_pkg::CFG_ASD_RELEASE_STEP: asd_release_step_reg <= wr_data;
                aae_pkg::CFG_SUSTAIN_LEVEL:    sustain_level_reg    <= wr_data;
                aae_pkg::CFG_SUSTAIN_MODE:     sustain_mode_reg     <= wr_data[0];
                aae_pkg::CFG_EOA_PULSE_TICKS:
                    eoa_pulse_ticks_reg <= wr_data[aae_pkg::PCNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata[2*MW:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            ad_reg        <= aae_pkg::ENV_RESET;
            asd_reg       <= aae_pkg::ENV_RESET;
            settle_reg    <= aae_pkg::SETTLE_W'(SETTLE_TICKS);
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                ad_reg        <= ad_next;
                asd_reg       <= asd_next;
                if (settling)
                begin
                    settle_reg <= settle_reg - 1'b1;
                end
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign settling  = settle_reg != '0;
    assign chained   = !in_data_reg[2*MW];
    assign ad_mv     = $signed(in_data_reg[MW-1:0]);
    assign asd_mv_in = $signed(in_data_reg[2*MW-1:MW]);
    assign asd_mv    = chained ? (ad_eoa ? aae_pkg::CHAIN_HIGH_MV : aae_pkg::GATE_LOW_MV)
                               : asd_mv_in;
    assign sus       = (sustain_level_reg > aae_pkg::LEVEL_ONE) ? aae_pkg::LEVEL_ONE
                                                                : sustain_level_reg;

    always_comb
    begin
        ad_ctrl.attack_step  = ad_attack_step_reg;
        ad_ctrl.release_step = ad_release_step_reg;
        ad_ctrl.target       = aae_pkg::LEVEL_ONE;
        ad_ctrl.hold_mode    = 1'b0;
        ad_ctrl.early_clear  = 1'b0;
        ad_ctrl.pulse_ticks  = eoa_pulse_ticks_reg;

        asd_ctrl.attack_step  = asd_attack_step_reg;
        asd_ctrl.release_step = asd_release_step_reg;
        asd_ctrl.target       = sus;
        asd_ctrl.hold_mode    = sustain_mode_reg;
        asd_ctrl.early_clear  = 1'b1;
        asd_ctrl.pulse_ticks  = eoa_pulse_ticks_reg;
    end

    aae_env_step u_ad_step
    (
        .cur          (ad_reg),
        .ctrl         (ad_ctrl),
        .mv           (ad_mv),
        .settling     (settling),
        .use_ext_held (1'b1),
        .ext_held     (1'b1),
        .nxt          (ad_next),
        .eoa          (ad_eoa)
    );

    aae_env_step u_asd_step
    (
        .cur          (asd_reg),
        .ctrl         (asd_ctrl),
        .mv           (asd_mv),
        .settling     (settling),
        .use_ext_held (chained),
        .ext_held     (ad_next.gate_high),
        .nxt          (asd_next),
        .eoa          (asd_eoa)
    );

    assign asd_out = (chained && (ad_next.level > asd_next.level)) ? ad_next.level
                                                                   : asd_next.level;

    assign out_data_next = {2'b00,
                            asd_next.release_done, asd_eoa, asd_out,
                            ad_next.release_done, ad_eoa, ad_next.level};

    a_ad_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[24:0] <= aae_pkg::LEVEL_ONE))
        else $error("AD level above full scale");

    a_ad_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (ad_reg.stage == aae_pkg::ST_OFF))
            |-> (m_tdata[24:0] == '0) && m_tdata[26])
        else $error("AD off but level or end-of-release wrong");

    a_asd_off_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (asd_reg.stage == aae_pkg::ST_OFF)) |-> m_tdata[53])
        else $error("ASD off without end-of-release");

    a_settle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(settle_reg) && $stable(ad_reg) && $stable(asd_reg))
        else $error("envelope state moved without an item");

endmodule
